@@ sv/glf_pkg.sv @@
// shared types and constants for the line glob filter
`timescale 1ns / 1ps
`default_nettype none

package glf_pkg;

  // pattern characters the configuration registers can hold
  localparam int unsigned PAT_SLOTS = 16;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM    = 8'd3;

  localparam logic [7:0] DELIM_RESET = 8'd10;

  // per-cell view of the pattern
  typedef struct packed {
    logic       live;
    logic [7:0] pchar;
  } cell_cfg_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic step;
    logic restart;
    logic refresh;
  } cell_ctl_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] length;
  } result_t;

endpackage

`default_nettype wire

@@ sv/glf_cell.sv @@
// one pattern position: stored and closed state bit plus its match logic
`timescale 1ns / 1ps
`default_nettype none

module glf_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire glf_pkg::cell_cfg_t cfg_i,
  input  wire glf_pkg::cell_ctl_t ctl_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              left_cur_i,
  input  wire logic              right_stay_i,
  input  wire logic              closed_i,
  output logic                   closed_o,
  output logic                   stay_o,
  output logic                   cur_o
);

  logic pos_q, pos_d;
  logic cur_q, cur_d;
  logic is_star;
  logic adv;
  logic raw;

  assign is_star = (cfg_i.pchar == glf_pkg::CH_STAR);

  // left neighbor reachable: a star keeps it, a hit moves it here
  assign stay_o = left_cur_i & cfg_i.live & is_star;
  assign adv    = left_cur_i & cfg_i.live & ~is_star &
                  ((cfg_i.pchar == glf_pkg::CH_ANY) | (cfg_i.pchar == byte_i));

  always_comb begin
    if (ctl_i.refresh) begin
      raw = pos_q;
    end else if (ctl_i.restart) begin
      raw = 1'b0;
    end else begin
      raw = adv | right_stay_i;
    end
  end

  // star closure ripples left to right through the row
  assign closed_o = cfg_i.live & (raw | (closed_i & is_star));

  always_comb begin
    pos_d = pos_q;
    cur_d = cur_q;
    if (ctl_i.refresh) begin
      cur_d = closed_o;
    end else if (ctl_i.restart) begin
      // a new line keeps only the bare start set, closure is redone on use
      pos_d = raw;
      cur_d = closed_o;
    end else if (ctl_i.step) begin
      pos_d = closed_o;
      cur_d = closed_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 1'b0;
      cur_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      cur_q <= cur_d;
    end
  end

  assign cur_o = cur_q;

endmodule

`default_nettype wire

@@ sv/glf_out_stage.sv @@
// result register between the matcher and the output channel
`timescale 1ns / 1ps
`default_nettype none

module glf_out_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire glf_pkg::result_t res_i,
  input  wire logic         stall_i,
  output logic              valid_o,
  output glf_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  glf_pkg::result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ sv/glob_line_filter.sv @@
// top level: line splitter and wildcard matcher over a row of position cells
`timescale 1ns / 1ps
`default_nettype none

// Filters a byte stream at one byte per clock while input is not stalled. Bytes
// up to the delimiter form a line; each delimiter beat yields one result with
// the match flag and the saturating line length, other bytes yield nothing. The
// pattern is held as a row of cells, one per pattern character, each carrying
// one bit of the reachable position set; the star closure ripples through the
// row in the same cycle, so that chain sets the clock. Input stall is raised in
// the cycle after every configuration write while the cells re-close their set
// over the new pattern, and a delimiter beat is also held off while the previous
// result is still stalled at the output. No clearing pass is needed after reset.
module glob_line_filter #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           data_valid_i,
  output logic                                data_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  output logic                                res_valid_o,
  input  wire logic                           res_stall_i,
  output logic                                line_matched_o,
  output logic [15:0]                         line_length_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [glf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [63:0]                    cfg_data_i
);

  localparam int unsigned CAP   = (PATTERN_MAX < glf_pkg::PAT_SLOTS) ?
                                  PATTERN_MAX : glf_pkg::PAT_SLOTS;
  localparam int unsigned CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
  localparam logic [4:0]       CAP_L = 5'(CAP);
  localparam logic [CNT_W-1:0] SAT   = '1;

  logic [63:0] pat_low_q, pat_high_q;
  logic [4:0]  pat_len_q;
  logic [7:0]  delim_q;
  logic        dirty_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        pos0_q, pos0_d, cur0_q, cur0_d;

  logic cfg_we;
  logic in_acc, is_delim, step, restart;
  logic [4:0] len_c;
  logic [CAP:0] cur_bits, stay, closed;
  logic hit_bit, hit;
  logic raw0;
  glf_pkg::cell_ctl_t ctl;
  glf_pkg::result_t   res_new, res_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      delim_q    <= glf_pkg::DELIM_RESET;
      dirty_q    <= 1'b0;
    end else begin
      dirty_q <= cfg_we;
      if (cfg_we) begin
        case (cfg_index_i)
          glf_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
          glf_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data_i;
          glf_pkg::REG_PAT_LEN:  pat_len_q  <= cfg_data_i[4:0];
          glf_pkg::REG_DELIM:    delim_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  assign len_c = (pat_len_q > CAP_L) ? CAP_L : pat_len_q;

  assign is_delim     = (data_byte_i == delim_q);
  assign data_stall_o = dirty_q | (res_valid_o & res_stall_i & is_delim);
  assign in_acc       = data_valid_i & ~data_stall_o;
  assign step         = in_acc & ~is_delim;
  assign restart      = in_acc & is_delim;

  assign ctl.step    = step;
  assign ctl.restart = restart;
  assign ctl.refresh = dirty_q;

  // position zero: start bit, always live
  always_comb begin
    if (dirty_q) begin
      raw0 = pos0_q;
    end else if (restart) begin
      raw0 = 1'b1;
    end else begin
      raw0 = stay[0];
    end
  end

  assign closed[0]   = raw0;
  assign cur_bits[0] = cur0_q;
  assign stay[CAP]   = 1'b0;

  always_comb begin
    pos0_d = pos0_q;
    cur0_d = cur0_q;
    if (dirty_q) begin
      cur0_d = raw0;
    end else if (step || restart) begin
      pos0_d = raw0;
      cur0_d = raw0;
    end
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    glf_pkg::cell_cfg_t ccfg;
    assign ccfg.live  = (5'(i) < len_c);
    if (i < 8) begin : g_lo
      assign ccfg.pchar = pat_low_q[8*i +: 8];
    end else begin : g_hi
      assign ccfg.pchar = pat_high_q[8*(i-8) +: 8];
    end

    glf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_i        (ccfg),
      .ctl_i        (ctl),
      .byte_i       (data_byte_i),
      .left_cur_i   (cur_bits[i]),
      .right_stay_i (stay[i+1]),
      .closed_i     (closed[i]),
      .closed_o     (closed[i+1]),
      .stay_o       (stay[i]),
      .cur_o        (cur_bits[i+1])
    );
  end

  // end position of the pattern reached
  always_comb begin
    hit_bit = 1'b0;
    for (int j = 1; j <= CAP; j++) begin
      if (len_c == 5'(j)) begin
        hit_bit = cur_bits[j];
      end
    end
  end

  assign hit = (len_c != 5'd0) & (cnt_q != '0) & hit_bit;

  always_comb begin
    cnt_d = cnt_q;
    if (restart) begin
      cnt_d = '0;
    end else if (step && (cnt_q != SAT)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos0_q <= 1'b1;
      cur0_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      pos0_q <= pos0_d;
      cur0_q <= cur0_d;
    end
  end

  assign res_new.matched = hit;
  assign res_new.length  = 16'(cnt_q);

  glf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (restart),
    .res_i   (res_new),
    .stall_i (res_stall_i),
    .valid_o (res_valid_o),
    .res_o   (res_out)
  );

  assign line_matched_o = res_out.matched;
  assign line_length_o  = res_out.length;

endmodule

`default_nettype wire

@@ sv/glf_checker.sv @@
// port-level checks for the line glob filter and their binding
`timescale 1ns / 1ps
`default_nettype none

module glf_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           data_valid_i,
  input wire logic                           data_stall_o,
  input wire logic                           res_valid_o,
  input wire logic                           res_stall_i,
  input wire logic                           line_matched_o,
  input wire logic [15:0]                    line_length_o,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o
);

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(line_matched_o) &&
    $stable(line_length_o))
    else $error("result beat changed under stall");

  // an empty line never matches
  a_empty_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && line_matched_o |-> line_length_o != 16'd0)
    else $error("empty line reported as match");

  // a new result only follows an accepted input beat
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(data_valid_i && !data_stall_o))
    else $error("result without input beat");

  // input is held off for the cycle after a register write
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> data_stall_o)
    else $error("input taken right after register write");

endmodule

bind glob_line_filter glf_checker u_glf_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
// self-checking testbench for the line glob filter
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned LIVE_MAX =
    (PATTERN_MAX < glf_pkg::PAT_SLOTS) ? PATTERN_MAX : glf_pkg::PAT_SLOTS;
  localparam logic [15:0] LEN_SAT =
    (LENGTH_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << LENGTH_BITS) - 1);
  localparam logic [31:0] LETTERS = "abcz";
  localparam int unsigned RANDOM_BYTES = 850;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic data_valid_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic res_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [glf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic data_stall_o;
  logic res_valid_o;
  logic line_matched_o;
  logic [15:0] line_length_o;
  logic cfg_ready_o;

  glob_line_filter #(
    .PATTERN_MAX(PATTERN_MAX),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_valid_i  (data_valid_i),
    .data_stall_o  (data_stall_o),
    .data_byte_i   (data_byte_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .line_matched_o(line_matched_o),
    .line_length_o (line_length_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial forever #6 clk_i = ~clk_i;

  // bytes waiting to be sent and line results waiting to come out
  logic [7:0] text_q[$];
  glf_pkg::result_t expected_lines[$];

  // shadow of the filter registers and line state
  logic [63:0] cfg_pat_low, cfg_pat_high;
  logic [4:0] cfg_pat_len;
  logic [7:0] cfg_delim;
  logic [16:0] reach_set;
  logic [15:0] cur_line_len;

  // stimulus side view of the current setup
  logic [7:0] gen_pat[16];
  logic [4:0] gen_len;
  logic [7:0] gen_delim = glf_pkg::DELIM_RESET;

  bit steady = 1'b0;
  int unsigned idle_left, stall_left;
  int unsigned mismatch_count, lines_checked, bytes_seen, setups;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 30) $display("[%0t] error: %s", $time, what);
  endtask

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned live_len();
    return (cfg_pat_len > LIVE_MAX) ? LIVE_MAX : int'(cfg_pat_len);
  endfunction

  function automatic logic [7:0] pattern_char(int unsigned i);
    return (i < 8) ? cfg_pat_low[i*8 +: 8] : cfg_pat_high[(i-8)*8 +: 8];
  endfunction

  // drop positions past the pattern end, then let every star skip ahead
  function automatic logic [16:0] close_stars(logic [16:0] s, int unsigned n);
    logic [16:0] r;
    r = s;
    for (int unsigned i = 0; i < 17; i++) if (i > n) r[i] = 1'b0;
    for (int unsigned i = 0; i < n; i++)
      if (r[i] && pattern_char(i) == glf_pkg::CH_STAR) r[i+1] = 1'b1;
    return r;
  endfunction

  task automatic advance_line(input logic [7:0] c);
    int unsigned n;
    logic [16:0] cur, nxt;
    glf_pkg::result_t r;
    n = live_len();
    cur = close_stars(reach_set, n);
    if (c == cfg_delim) begin
      r.matched = (n > 0) && (cur_line_len != 0) && cur[n];
      r.length = cur_line_len;
      expected_lines.push_back(r);
      reach_set = 17'd1;
      cur_line_len = '0;
    end else begin
      nxt = '0;
      for (int unsigned i = 0; i < n; i++) begin
        if (cur[i]) begin
          if (pattern_char(i) == glf_pkg::CH_STAR) nxt[i] = 1'b1;
          else if (pattern_char(i) == glf_pkg::CH_ANY || pattern_char(i) == c)
            nxt[i+1] = 1'b1;
        end
      end
      reach_set = close_stars(nxt, n);
      if (cur_line_len < LEN_SAT) cur_line_len = cur_line_len + 16'd1;
    end
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
      else b = LETTERS[$urandom_range(0, 3)*8 +: 8];
    end while (b == gen_delim);
    return b;
  endfunction

  // driver: one byte beat per handshake, random gaps after some beats unless steady
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_valid_i <= 1'b0;
      data_byte_i <= '0;
      idle_left <= 0;
    end else if (data_valid_i && data_stall_o) begin
      // hold the stalled beat
    end else if (idle_left != 0) begin
      data_valid_i <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (text_q.size() != 0) begin
      data_valid_i <= 1'b1;
      data_byte_i <= text_q.pop_front();
      idle_left <= (steady || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    end else begin
      data_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      res_stall_i <= 1'b0;
      if (!steady && $urandom_range(0, 7) == 0) stall_left <= gap_len();
    end
  end

  // monitor: tracks register writes and byte beats, checks result beats
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    glf_pkg::result_t want;
    if (!rst_ni) begin
      cfg_pat_low = '0;
      cfg_pat_high = '0;
      cfg_pat_len = '0;
      cfg_delim = glf_pkg::DELIM_RESET;
      reach_set = 17'd1;
      cur_line_len = '0;
      expected_lines.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          glf_pkg::REG_PAT_LOW:  cfg_pat_low = cfg_data_i;
          glf_pkg::REG_PAT_HIGH: cfg_pat_high = cfg_data_i;
          glf_pkg::REG_PAT_LEN:  cfg_pat_len = cfg_data_i[4:0];
          glf_pkg::REG_DELIM:    cfg_delim = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (data_valid_i && !data_stall_o) begin
        bytes_seen++;
        advance_line(data_byte_i);
      end
      if (res_valid_o && !res_stall_i) begin
        if (expected_lines.size() == 0) begin
          flag_mismatch($sformatf("result beat with no line pending (matched %0b length %0d)",
                                  line_matched_o, line_length_o));
        end else begin
          want = expected_lines.pop_front();
          lines_checked++;
          if (line_matched_o !== want.matched)
            flag_mismatch($sformatf("line %0d: matched %0b, want %0b",
                                    lines_checked, line_matched_o, want.matched));
          if (line_length_o !== want.length)
            flag_mismatch($sformatf("line %0d: length %0d, want %0d",
                                    lines_checked, line_length_o, want.length));
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (text_q.size() != 0 || data_valid_i || expected_lines.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [glf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // load gen_* into the block once it has gone quiet
  task automatic program_filter(input bit write_delim);
    logic [63:0] low, high, len_word;
    for (int i = 0; i < 8; i++) begin
      low[i*8 +: 8] = gen_pat[i];
      high[i*8 +: 8] = gen_pat[i+8];
    end
    len_word = {$urandom, $urandom};
    // junk above the length field now and then
    len_word = ($urandom_range(0, 3) == 0) ? {len_word[63:5], gen_len} : {59'd0, gen_len};
    wait_drained();
    @(posedge clk_i);
    write_reg(glf_pkg::REG_PAT_LOW, low);
    write_reg(glf_pkg::REG_PAT_HIGH, high);
    write_reg(glf_pkg::REG_PAT_LEN, len_word);
    if (write_delim) write_reg(glf_pkg::REG_DELIM, {56'd0, gen_delim});
    cfg_valid_i <= 1'b0;
    setups++;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent, n_lines, eff, r, k;
    logic [7:0] line_q[$];
    bit write_delim;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setup: empty pattern, a one-byte line, then an empty line
    text_q.push_back(8'h78);
    text_q.push_back(glf_pkg::DELIM_RESET);
    text_q.push_back(glf_pkg::DELIM_RESET);

    // a?*<nul>* with delimiter 0xff
    foreach (gen_pat[i]) gen_pat[i] = 8'h00;
    gen_pat[0] = 8'h61;
    gen_pat[1] = glf_pkg::CH_ANY;
    gen_pat[2] = glf_pkg::CH_STAR;
    gen_pat[3] = 8'h00;
    gen_pat[4] = glf_pkg::CH_STAR;
    gen_len = 5'd5;
    gen_delim = 8'hFF;
    program_filter(1'b1);
    text_q.push_back(8'h61);
    text_q.push_back(8'h62);
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h61);
    text_q.push_back(8'hFF);
    text_q.push_back(8'hFF);

    // sixteen '?' with an oversized length, delimiter 0x00
    foreach (gen_pat[i]) gen_pat[i] = glf_pkg::CH_ANY;
    gen_len = 5'd31;
    gen_delim = 8'h00;
    program_filter(1'b1);
    repeat (16) text_q.push_back(8'hFF);
    text_q.push_back(8'h00);

    // one long line whose last byte is the closing literal, then a short one
    foreach (gen_pat[i]) gen_pat[i] = 8'h00;
    gen_pat[0] = glf_pkg::CH_ANY;
    gen_pat[1] = glf_pkg::CH_STAR;
    gen_pat[2] = 8'h7A;
    gen_len = 5'd3;
    gen_delim = glf_pkg::DELIM_RESET;
    program_filter(1'b1);
    steady = 1'b1;
    text_q.push_back(8'h71);
    repeat (200) text_q.push_back(text_byte());
    text_q.push_back(8'h7A);
    text_q.push_back(gen_delim);
    text_q.push_back(8'h71);
    text_q.push_back(8'h7A);
    text_q.push_back(gen_delim);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      write_delim = (setups < 5) || ($urandom_range(0, 2) == 0);
      if (write_delim)
        gen_delim = ($urandom_range(0, 9) < 7) ? glf_pkg::DELIM_RESET :
                                                 8'($urandom_range(0, 255));
      foreach (gen_pat[i]) begin
        r = $urandom_range(0, 99);
        if (r < 25) gen_pat[i] = glf_pkg::CH_STAR;
        else if (r < 45) gen_pat[i] = glf_pkg::CH_ANY;
        else if (r < 88) gen_pat[i] = LETTERS[$urandom_range(0, 3)*8 +: 8];
        else if (r < 94) gen_pat[i] = gen_delim;
        else gen_pat[i] = 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 6) gen_len = 5'd0;
      else if (r < 12) gen_len = 5'd16;
      else if (r < 18) gen_len = 5'($urandom_range(17, 31));
      else if (r < 30) gen_len = 5'($urandom_range(9, 15));
      else gen_len = 5'($urandom_range(1, 8));
      program_filter(write_delim);
      steady = ($urandom_range(0, 4) == 0);
      eff = (gen_len > LIVE_MAX) ? LIVE_MAX : int'(gen_len);

      n_lines = $urandom_range(4, 16);
      for (int ln = 0; ln < n_lines; ln++) begin
        line_q.delete();
        if ($urandom_range(0, 9) < 7) begin
          // text shaped by the pattern, sometimes damaged
          for (int i = 0; i < eff; i++) begin
            if (gen_pat[i] == glf_pkg::CH_STAR)
              repeat ($urandom_range(0, 3)) line_q.push_back(text_byte());
            else if (gen_pat[i] == glf_pkg::CH_ANY) line_q.push_back(text_byte());
            else line_q.push_back(gen_pat[i]);
          end
          if (line_q.size() != 0 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, line_q.size() - 1);
            if ($urandom_range(0, 1) == 0) line_q[k] = text_byte();
            else line_q.delete(k);
          end
        end else begin
          repeat ($urandom_range(0, 10)) line_q.push_back(text_byte());
        end
        // the last line is sometimes left open across the next setup
        if (ln != n_lines - 1 || $urandom_range(0, 4) != 0) line_q.push_back(gen_delim);
        sent += line_q.size();
        foreach (line_q[i]) text_q.push_back(line_q[i]);
      end
    end

    wait_drained();
    $display("%0d line results checked over %0d bytes and %0d filter setups",
             lines_checked, bytes_seen, setups);
    $display("setups spanned empty, full and clamped patterns and delimiters 0x00 to 0xff");
    if (mismatch_count == 0) begin
      $display("glob_line_filter: match");
    end else begin
      $display("glob_line_filter: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("glob_line_filter: mismatch");
    $finish;
  end

endmodule

@@ glob_line_filter.f @@
sv/glf_pkg.sv
sv/glf_cell.sv
sv/glf_out_stage.sv
sv/glob_line_filter.sv
sv/glf_checker.sv
dv/tb.sv
